[src/ppj_pkg.sv]
`default_nettype none
package ppj_pkg;

  typedef enum logic [1:0] {
    ST_STORED  = 2'd0,
    ST_DROPPED = 2'd1,
    ST_READ    = 2'd2,
    ST_OUTSIDE = 2'd3
  } status_e;

  typedef enum logic [2:0] {
    CFG_FOCAL_X = 3'd0,
    CFG_FOCAL_Y = 3'd1,
    CFG_PRINC_X = 3'd2,
    CFG_PRINC_Y = 3'd3,
    CFG_WIDTH   = 3'd4,
    CFG_HEIGHT  = 3'd5
  } cfg_idx_e;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam logic [23:0] FOCAL_X_RST = 24'd2048000;
  localparam logic [23:0] FOCAL_Y_RST = 24'd2048000;
  localparam logic [23:0] PRINC_X_RST = 24'd1310720;
  localparam logic [23:0] PRINC_Y_RST = 24'd983040;
  localparam logic [10:0] WIDTH_RST   = 11'd640;
  localparam logic [10:0] HEIGHT_RST  = 11'd480;

  localparam logic [31:0] DEPTH_EMPTY = 32'h7FFF_FFFF;

  // working width of the divider: numerator magnitude stays below 2^57
  localparam int REM_W = 58;
  localparam int CAM_FRAC = 12;

  typedef struct packed {
    logic               opcode;
    logic signed [31:0] point_x;
    logic signed [31:0] point_y;
    logic signed [31:0] point_z;
    logic [9:0]         read_col;
    logic [9:0]         read_row;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [9:0]         pixel_col;
    logic [9:0]         pixel_row;
    logic signed [31:0] depth_out;
    logic               pixel_written;
  } res_t;

  typedef struct packed {
    logic capture;
    logic mul;
    logic div_init;
    logic div_step;
    logic latch;
    logic axis;
    logic mem_rd;
    logic fin;
    logic clr;
  } cmd_t;

  typedef struct packed {
    logic is_read;
    logic z_zero;
    logic in_frame;
    logic div_last;
    logic clr_last;
  } sts_t;

endpackage
`default_nettype wire

[src/ppj_ram.sv]
`default_nettype none
module ppj_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic                     re_i,
  input  wire logic [AW-1:0]            addr_i,
  input  wire logic [WIDTH-1:0]         wdata_i,
  output logic      [WIDTH-1:0]         rdata_o
);
  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;
endmodule
`default_nettype wire

[src/ppj_ctrl.sv]
`default_nettype none
module ppj_ctrl (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start_i,
  output logic               busy_o,
  output logic               res_valid_o,
  output ppj_pkg::cmd_t      cmd_o,
  input  wire ppj_pkg::sts_t sts_i
);
  typedef enum logic [8:0] {
    S_CLEAR = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_CHECK = 9'b000000100,
    S_MUL   = 9'b000001000,
    S_DINIT = 9'b000010000,
    S_DIV   = 9'b000100000,
    S_LATCH = 9'b001000000,
    S_RD    = 9'b010000000,
    S_FIN   = 9'b100000000
  } state_e;

  state_e state_q, state_d;
  logic   axis_q, axis_d;
  logic   res_valid_q, res_valid_d;

  always_comb begin
    state_d     = state_q;
    axis_d      = axis_q;
    res_valid_d = 1'b0;
    cmd_o       = '0;
    cmd_o.axis  = axis_q;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr = 1'b1;
        if (sts_i.clr_last) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start_i) begin
          cmd_o.capture = 1'b1;
          state_d       = S_CHECK;
        end
      end
      S_CHECK: begin
        axis_d = 1'b0;
        if (sts_i.is_read) begin
          state_d = sts_i.in_frame ? S_RD : S_FIN;
        end else begin
          state_d = sts_i.z_zero ? S_FIN : S_MUL;
        end
      end
      S_MUL: begin
        cmd_o.mul = 1'b1;
        state_d   = S_DINIT;
      end
      S_DINIT: begin
        cmd_o.div_init = 1'b1;
        state_d        = S_DIV;
      end
      S_DIV: begin
        cmd_o.div_step = 1'b1;
        if (sts_i.div_last) state_d = S_LATCH;
      end
      S_LATCH: begin
        cmd_o.latch = 1'b1;
        axis_d      = 1'b1;
        state_d     = axis_q ? S_RD : S_MUL;
      end
      S_RD: begin
        cmd_o.mem_rd = 1'b1;
        state_d      = S_FIN;
      end
      S_FIN: begin
        cmd_o.fin   = 1'b1;
        res_valid_d = 1'b1;
        state_d     = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      axis_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      axis_q      <= axis_d;
      res_valid_q <= res_valid_d;
    end
  end

  assign busy_o      = (state_q != S_IDLE);
  assign res_valid_o = res_valid_q;
endmodule
`default_nettype wire

[src/ppj_dp.sv]
`default_nettype none
module ppj_dp #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            cfg_we_i,
  input  wire logic [ppj_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ppj_pkg::CFG_DATA_W-1:0]  cfg_data_i,
  input  wire ppj_pkg::req_t                   req_i,
  output ppj_pkg::res_t                        res_o,
  input  wire ppj_pkg::cmd_t                   cmd_i,
  output ppj_pkg::sts_t                        sts_o
);
  localparam int CW    = (MAX_WIDTH > 1) ? $clog2(MAX_WIDTH) : 1;
  localparam int RW    = (MAX_HEIGHT > 1) ? $clog2(MAX_HEIGHT) : 1;
  localparam int QB    = (CW > RW) ? CW : RW;
  localparam int QW    = QB + 1;
  localparam int SCW   = $clog2(QB + 1);
  localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CMPW  = (QW > 10) ? QW : 10;
  localparam int RMW   = ppj_pkg::REM_W;

  // configuration registers
  logic [23:0] focal_x_q, focal_y_q, princ_x_q, princ_y_q;
  logic [10:0] width_q, height_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      focal_x_q <= ppj_pkg::FOCAL_X_RST;
      focal_y_q <= ppj_pkg::FOCAL_Y_RST;
      princ_x_q <= ppj_pkg::PRINC_X_RST;
      princ_y_q <= ppj_pkg::PRINC_Y_RST;
      width_q   <= ppj_pkg::WIDTH_RST;
      height_q  <= ppj_pkg::HEIGHT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        ppj_pkg::CFG_FOCAL_X: focal_x_q <= cfg_data_i;
        ppj_pkg::CFG_FOCAL_Y: focal_y_q <= cfg_data_i;
        ppj_pkg::CFG_PRINC_X: princ_x_q <= cfg_data_i;
        ppj_pkg::CFG_PRINC_Y: princ_y_q <= cfg_data_i;
        ppj_pkg::CFG_WIDTH:   width_q   <= cfg_data_i[10:0];
        ppj_pkg::CFG_HEIGHT:  height_q  <= cfg_data_i[10:0];
        default: ;
      endcase
    end
  end

  // frame size in use, zero taken as one and saturated to the store
  logic [QW-1:0] w_eff, h_eff;
  always_comb begin
    if (width_q == '0) w_eff = QW'(1);
    else if (32'(width_q) > 32'(MAX_WIDTH)) w_eff = QW'(MAX_WIDTH);
    else w_eff = QW'(width_q);
    if (height_q == '0) h_eff = QW'(1);
    else if (32'(height_q) > 32'(MAX_HEIGHT)) h_eff = QW'(MAX_HEIGHT);
    else h_eff = QW'(height_q);
  end

  ppj_pkg::req_t req_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.capture) req_q <= req_i;
  end

  logic z_neg;
  logic in_frame;
  assign z_neg    = req_q.point_z[31];
  assign in_frame = (CMPW'(req_q.read_col) < CMPW'(w_eff)) &&
                    (CMPW'(req_q.read_row) < CMPW'(h_eff));

  // products of one axis
  logic signed [56:0] pf_q, cz_q;
  logic signed [31:0] p_sel;
  logic        [23:0] f_sel, c_sel;
  assign p_sel = cmd_i.axis ? req_q.point_y : req_q.point_x;
  assign f_sel = cmd_i.axis ? focal_y_q : focal_x_q;
  assign c_sel = cmd_i.axis ? princ_y_q : princ_x_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.mul) begin
      pf_q <= 57'(p_sel) * 57'($signed({1'b0, f_sel}));
      cz_q <= 57'($signed({1'b0, c_sel})) * 57'(req_q.point_z);
    end
  end

  // restoring divider, one quotient bit per step, top bit flags saturation
  logic signed [RMW-1:0] num, num_adj;
  logic        [31:0]    zabs;
  logic        [RMW-1:0] rem_q, den_q;
  logic        [QW-1:0]  quo_q;
  logic                  neg_q;
  logic        [SCW-1:0] cnt_q;
  logic                  ge;

  assign num     = RMW'(pf_q) + RMW'(cz_q);
  assign num_adj = z_neg ? -num : num;
  assign zabs    = z_neg ? 32'(-req_q.point_z) : 32'(req_q.point_z);
  assign ge      = (rem_q >= den_q);

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_init) begin
      neg_q <= num_adj[RMW-1];
      rem_q <= num_adj[RMW-1] ? '0 : RMW'(num_adj);
      den_q <= RMW'(zabs) << (ppj_pkg::CAM_FRAC + QB);
      quo_q <= '0;
      cnt_q <= SCW'(QB);
    end else if (cmd_i.div_step) begin
      if (ge) rem_q <= rem_q - den_q;
      quo_q <= {quo_q[QW-2:0], ge};
      den_q <= den_q >> 1;
      cnt_q <= cnt_q - SCW'(1);
    end
  end

  logic [QW-1:0] lim, clamped;
  assign lim = cmd_i.axis ? h_eff : w_eff;
  always_comb begin
    if (neg_q) clamped = '0;
    else if (quo_q >= lim) clamped = lim - QW'(1);
    else clamped = quo_q;
  end

  logic [CW-1:0] col_q;
  logic [RW-1:0] row_q;
  always_ff @(posedge clk_i) begin
    if (cmd_i.latch) begin
      if (cmd_i.axis) row_q <= RW'(clamped);
      else col_q <= CW'(clamped);
    end
  end

  // pixel stores
  logic [CW-1:0] a_col;
  logic [RW-1:0] a_row;
  logic [AW-1:0] pix_addr, clr_q, ram_addr;
  logic          v_we, v_wdata, v_rdata, d_we;
  logic [31:0]   d_rdata;

  assign a_col    = req_q.opcode ? CW'(req_q.read_col) : col_q;
  assign a_row    = req_q.opcode ? RW'(req_q.read_row) : row_q;
  assign pix_addr = AW'(a_row) * AW'(MAX_WIDTH) + AW'(a_col);
  assign ram_addr = cmd_i.clr ? clr_q : pix_addr;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) clr_q <= '0;
    else if (cmd_i.clr) clr_q <= clr_q + AW'(1);
  end

  logic do_store, do_clear;
  assign do_store = cmd_i.fin && !req_q.opcode && (req_q.point_z != '0);
  assign do_clear = cmd_i.fin && req_q.opcode && in_frame;
  assign v_we     = cmd_i.clr || do_store || do_clear;
  assign v_wdata  = do_store;
  assign d_we     = do_store;

  ppj_ram #(.WIDTH(1), .DEPTH(DEPTH)) u_valid (
    .clk_i   (clk_i),
    .we_i    (v_we),
    .re_i    (cmd_i.mem_rd),
    .addr_i  (ram_addr),
    .wdata_i (v_wdata),
    .rdata_o (v_rdata)
  );

  ppj_ram #(.WIDTH(32), .DEPTH(DEPTH)) u_depth (
    .clk_i   (clk_i),
    .we_i    (d_we),
    .re_i    (cmd_i.mem_rd),
    .addr_i  (ram_addr),
    .wdata_i (req_q.point_z),
    .rdata_o (d_rdata)
  );

  // result beat
  ppj_pkg::res_t res_q, res_d;
  always_comb begin
    res_d = '0;
    if (req_q.opcode) begin
      res_d.pixel_col = req_q.read_col;
      res_d.pixel_row = req_q.read_row;
      if (in_frame) begin
        res_d.status        = ppj_pkg::ST_READ;
        res_d.pixel_written = v_rdata;
        res_d.depth_out     = v_rdata ? d_rdata : ppj_pkg::DEPTH_EMPTY;
      end else begin
        res_d.status    = ppj_pkg::ST_OUTSIDE;
        res_d.depth_out = ppj_pkg::DEPTH_EMPTY;
      end
    end else if (req_q.point_z == '0) begin
      res_d.status = ppj_pkg::ST_DROPPED;
    end else begin
      res_d.status        = ppj_pkg::ST_STORED;
      res_d.pixel_col     = 10'(col_q);
      res_d.pixel_row     = 10'(row_q);
      res_d.depth_out     = req_q.point_z;
      res_d.pixel_written = v_rdata;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin) res_q <= res_d;
  end

  assign res_o = res_q;

  assign sts_o.is_read  = req_q.opcode;
  assign sts_o.z_zero   = (req_q.point_z == '0);
  assign sts_o.in_frame = in_frame;
  assign sts_o.div_last = (cnt_q == '0);
  assign sts_o.clr_last = (clr_q == AW'(DEPTH - 1));
endmodule
`default_nettype wire

[src/point_to_depth_image_projector.sv]
// channel   | handshake               | payload
// request   | start, busy             | req_i (ppj_pkg::req_t)
// result    | res_valid_o (one cycle) | res_o (ppj_pkg::res_t)
// config    | cfg_we_i                | cfg_idx_i, cfg_data_i
// a project beat runs the bit-serial divider once per axis, its quotient sized by QB,
// the index width of the larger frame side (10 at 1024x1024); a read inside the frame
// reads the stores, a zero-depth point or a read outside the frame goes straight to
// the result; the next beat can be taken while the strobe is high
// after reset the valid store is swept, busy high
// one beat in flight; the result strobe cannot be held off
`default_nettype none
module point_to_depth_image_projector #(
  parameter int MAX_WIDTH  = 1024,
  parameter int MAX_HEIGHT = 1024
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            start,
  output logic                                 busy,
  input  wire ppj_pkg::req_t                   req_i,
  output logic                                 res_valid_o,
  output ppj_pkg::res_t                        res_o,
  input  wire logic                            cfg_we_i,
  input  wire logic [ppj_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [ppj_pkg::CFG_DATA_W-1:0]  cfg_data_i
);
  ppj_pkg::cmd_t cmd;
  ppj_pkg::sts_t sts;

  ppj_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (start),
    .busy_o      (busy),
    .res_valid_o (res_valid_o),
    .cmd_o       (cmd),
    .sts_i       (sts)
  );

  ppj_dp #(.MAX_WIDTH(MAX_WIDTH), .MAX_HEIGHT(MAX_HEIGHT)) u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .req_i      (req_i),
    .res_o      (res_o),
    .cmd_i      (cmd),
    .sts_o      (sts)
  );
endmodule
`default_nettype wire

[src/ppj_checker.sv]
`default_nettype none
module ppj_checker (
  input wire logic          clk_i,
  input wire logic          rst_ni,
  input wire logic          start,
  input wire logic          busy,
  input wire logic          res_valid_o,
  input wire ppj_pkg::res_t res_o
);
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted beat did not raise busy");

  a_res_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> !busy) else $error("result while busy");

  a_res_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |=> !res_valid_o) else $error("back to back results");

  a_drop_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ppj_pkg::ST_DROPPED) |->
      (res_o.pixel_col == '0 && res_o.pixel_row == '0 &&
       res_o.depth_out == '0 && !res_o.pixel_written))
    else $error("dropped point with nonzero fields");

  a_outside: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (res_valid_o && res_o.status == ppj_pkg::ST_OUTSIDE) |->
      (res_o.depth_out == ppj_pkg::DEPTH_EMPTY && !res_o.pixel_written))
    else $error("outside read with data");
endmodule

bind point_to_depth_image_projector ppj_checker u_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .start       (start),
  .busy        (busy),
  .res_valid_o (res_valid_o),
  .res_o       (res_o)
);
`default_nettype wire
